### sv/mphi_pkg.sv
package mphi_pkg;

   localparam int MAX_ORDER_DEF = 4;
   localparam int VOCAB_DEF     = 4096;
   localparam int G_ENTRIES_DEF = 65536;

   localparam int FUNC_W    = 2;
   localparam int LEVEL_W   = 2;
   localparam int ADDR_W    = 16;
   localparam int VALUE_W   = 31;
   localparam int WORD_W    = 12;
   localparam int SLOT_W    = 16;
   localparam int DEPTH_W   = 3;
   localparam int LEN_W     = 17;
   localparam int REQ_DATA_W = 64;

   localparam int LEVEL_LSB = 0;
   localparam int ADDR_LSB  = LEVEL_LSB + LEVEL_W;
   localparam int VALUE_LSB = ADDR_LSB + ADDR_W;
   localparam int WORD_LSB  = VALUE_LSB + VALUE_W;

   localparam int SLOT_LIMIT = 65536;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 3'd3;
   localparam logic [LEN_W-1:0]   GLEN_RESET   = 17'd65536;
   localparam logic [LEN_W-1:0]   SCOUNT_RESET = 17'd32768;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_G_LENGTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WR_FIRST  = 2'd0,
      FUNC_WR_SECOND = 2'd1,
      FUNC_WR_G      = 2'd2,
      FUNC_KEY_WORD  = 2'd3
   } func_type;

endpackage

### sv/mphi_rand_tables.sv
module mphi_rand_tables #(
   parameter int ENTRIES = 16384,
   parameter int AW      = 14
) (
   input  logic                          clock,
   input  logic                          wr_first,
   input  logic                          wr_second,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [mphi_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [mphi_pkg::VALUE_W-1:0]  rd_first,
   output logic [mphi_pkg::VALUE_W-1:0]  rd_second
);

   logic [mphi_pkg::VALUE_W-1:0] first_mem [ENTRIES];
   logic [mphi_pkg::VALUE_W-1:0] second_mem [ENTRIES];
   logic [mphi_pkg::VALUE_W-1:0] rd_first_ff;
   logic [mphi_pkg::VALUE_W-1:0] rd_second_ff;

   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[wr_addr] <= wr_data;
      end
      if (wr_second) begin
         second_mem[wr_addr] <= wr_data;
      end
      rd_first_ff  <= first_mem[rd_addr];
      rd_second_ff <= second_mem[rd_addr];
   end

   assign rd_first  = rd_first_ff;
   assign rd_second = rd_second_ff;

endmodule

### sv/mphi_g_table.sv
module mphi_g_table #(
   parameter int ENTRIES = 65536,
   parameter int AW      = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [mphi_pkg::VALUE_W-1:0]  wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [mphi_pkg::VALUE_W-1:0]  rd_data
);

   logic [mphi_pkg::VALUE_W-1:0] g_mem [ENTRIES];
   logic [mphi_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         g_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= g_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mphi_mod.sv
module mphi_mod #(
   parameter int DW = 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DW-1:0]               dividend,
   input  logic [mphi_pkg::LEN_W-1:0]  divisor,
   output logic                        done,
   output logic [mphi_pkg::LEN_W-1:0]  remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0]              dvd_ff, dvd_in;
   logic [mphi_pkg::LEN_W-1:0] dsr_ff, dsr_in;
   logic [mphi_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [mphi_pkg::LEN_W:0]   trial;

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[DW-1]};
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = mphi_pkg::LEN_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = mphi_pkg::LEN_W'(trial);
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### sv/minimal_perfect_hash_index_core.sv
// Minimal perfect hash index over multi-word keys. Load transactions (tuser 0, 1, 2) write one
// entry of the first or second per-level random table or of the g table without leaving the
// idle state. Key-word transactions (tuser 3) are a read of both random tables, then an add
// into the u and v accumulators. The word that completes a key also runs the accumulators
// through two bit-serial remainder units (one bit per cycle), reads g[u] and g[v] from the g
// table memory, and reduces their sum by sample_count on the first of the units; the block
// takes no new transaction until that slot is in the output register. The dividend width is
// the larger of 32 and the accumulator width (31 plus log2 of MAX_ORDER). The slot
// waits in the output register, so the next transaction is taken while it is unclaimed. Table
// contents are undefined after reset and must be loaded before keys are hashed.
module minimal_perfect_hash_index_core #(
   parameter int MAX_ORDER = mphi_pkg::MAX_ORDER_DEF,
   parameter int VOCAB     = mphi_pkg::VOCAB_DEF,
   parameter int G_ENTRIES = mphi_pkg::G_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // level [1:0], address [17:2], value [48:18], word [60:49], zero [63:61]
   input  logic [mphi_pkg::REQ_DATA_W-1:0]       req_tdata,
   // func [1:0]
   input  logic [mphi_pkg::FUNC_W-1:0]           req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // slot [15:0]
   output logic [mphi_pkg::SLOT_W-1:0]           rsp_tdata,
   input  logic                                  csr_we,
   input  logic [mphi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mphi_pkg::LEN_W-1:0]            csr_wdata
);

   localparam int RT_ENTRIES = MAX_ORDER * VOCAB;
   localparam int RA_W  = (RT_ENTRIES > 1) ? $clog2(RT_ENTRIES) : 1;
   localparam int GA_W  = $clog2(G_ENTRIES);
   localparam int PW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int SUM_W = mphi_pkg::VALUE_W + $clog2(MAX_ORDER);
   localparam int DW    = (SUM_W > 32) ? SUM_W : 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV_UV,
      ST_RD_GU,
      ST_RD_GV,
      ST_DIV_SLOT,
      ST_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [PW-1:0]                      pos_ff, pos_in;
   logic [SUM_W-1:0]                   sum_u_ff, sum_u_in;
   logic [SUM_W-1:0]                   sum_v_ff, sum_v_in;
   logic                               word_ok_ff, word_ok_in;
   logic                               last_ff, last_in;
   logic [GA_W-1:0]                    v_ff, v_in;
   logic [mphi_pkg::VALUE_W-1:0]       gu_ff, gu_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [mphi_pkg::SLOT_W-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [mphi_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic [mphi_pkg::LEN_W-1:0]         glen_ff, glen_in;
   logic [mphi_pkg::LEN_W-1:0]         scount_ff, scount_in;

   mphi_pkg::func_type                 func;
   logic [mphi_pkg::LEVEL_W-1:0]       level;
   logic [mphi_pkg::ADDR_W-1:0]        address;
   logic [mphi_pkg::VALUE_W-1:0]       value;
   logic [mphi_pkg::WORD_W-1:0]        word;
   logic                               accept;

   logic [mphi_pkg::DEPTH_W-1:0]       depth_eff;
   logic [mphi_pkg::LEN_W-1:0]         gm;
   logic [mphi_pkg::LEN_W-1:0]         sm;

   logic                               rt_wr_first, rt_wr_second;
   logic [RA_W-1:0]                    rt_wr_addr, rt_rd_addr;
   logic [mphi_pkg::VALUE_W-1:0]       rt_rd_first, rt_rd_second;
   logic                               g_wr_en;
   logic [GA_W-1:0]                    g_wr_addr, g_rd_addr;
   logic [mphi_pkg::VALUE_W-1:0]       g_rd_data;

   logic [SUM_W-1:0]                   sum_u_add, sum_v_add;
   logic [31:0]                        g_total;
   logic                               start_a, start_b;
   logic [DW-1:0]                      dvd_a, dvd_b;
   logic [mphi_pkg::LEN_W-1:0]         dsr_a;
   logic                               done_a, done_b;
   logic [mphi_pkg::LEN_W-1:0]         rem_a, rem_b;

   assign func    = mphi_pkg::func_type'(req_tuser);
   assign level   = req_tdata[mphi_pkg::LEVEL_LSB +: mphi_pkg::LEVEL_W];
   assign address = req_tdata[mphi_pkg::ADDR_LSB +: mphi_pkg::ADDR_W];
   assign value   = req_tdata[mphi_pkg::VALUE_LSB +: mphi_pkg::VALUE_W];
   assign word    = req_tdata[mphi_pkg::WORD_LSB +: mphi_pkg::WORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (depth_ff == '0) begin
         depth_eff = mphi_pkg::DEPTH_W'(1);
      end else if (32'(depth_ff) > 32'(MAX_ORDER)) begin
         depth_eff = mphi_pkg::DEPTH_W'(MAX_ORDER);
      end else begin
         depth_eff = depth_ff;
      end
      if (glen_ff == '0) begin
         gm = mphi_pkg::LEN_W'(1);
      end else if (32'(glen_ff) > 32'(G_ENTRIES)) begin
         gm = mphi_pkg::LEN_W'(G_ENTRIES);
      end else begin
         gm = glen_ff;
      end
      if (scount_ff == '0) begin
         sm = mphi_pkg::LEN_W'(1);
      end else if (32'(scount_ff) > 32'(mphi_pkg::SLOT_LIMIT)) begin
         sm = mphi_pkg::LEN_W'(mphi_pkg::SLOT_LIMIT);
      end else begin
         sm = scount_ff;
      end
   end

   assign rt_wr_addr = RA_W'(RA_W'(level) * RA_W'(VOCAB) + RA_W'(address));
   assign rt_rd_addr = RA_W'(RA_W'(pos_ff) * RA_W'(VOCAB) + RA_W'(word));
   assign rt_wr_first  = accept && (func == mphi_pkg::FUNC_WR_FIRST)
                         && (32'(level) < 32'(MAX_ORDER)) && (32'(address) < 32'(VOCAB));
   assign rt_wr_second = accept && (func == mphi_pkg::FUNC_WR_SECOND)
                         && (32'(level) < 32'(MAX_ORDER)) && (32'(address) < 32'(VOCAB));
   assign g_wr_en   = accept && (func == mphi_pkg::FUNC_WR_G)
                      && (32'(address) < 32'(G_ENTRIES));
   assign g_wr_addr = GA_W'(address);

   mphi_rand_tables #(
      .ENTRIES (RT_ENTRIES),
      .AW      (RA_W)
   ) u_rand_tables (
      .clock     (clock),
      .wr_first  (rt_wr_first),
      .wr_second (rt_wr_second),
      .wr_addr   (rt_wr_addr),
      .wr_data   (value),
      .rd_addr   (rt_rd_addr),
      .rd_first  (rt_rd_first),
      .rd_second (rt_rd_second)
   );

   mphi_g_table #(
      .ENTRIES (G_ENTRIES),
      .AW      (GA_W)
   ) u_g_table (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (value),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   assign sum_u_add = sum_u_ff + (word_ok_ff ? SUM_W'(rt_rd_first) : '0);
   assign sum_v_add = sum_v_ff + (word_ok_ff ? SUM_W'(rt_rd_second) : '0);
   assign g_total   = 32'(gu_ff) + 32'(g_rd_data);

   assign start_a = ((state_ff == ST_ACC) && last_ff) || (state_ff == ST_RD_GV);
   assign start_b = (state_ff == ST_ACC) && last_ff;
   assign dvd_a   = (state_ff == ST_ACC) ? DW'(sum_u_add) : DW'(g_total);
   assign dvd_b   = DW'(sum_v_add);
   assign dsr_a   = (state_ff == ST_ACC) ? gm : sm;

   mphi_mod #(
      .DW (DW)
   ) u_mod_a (
      .clock     (clock),
      .reset     (reset),
      .start     (start_a),
      .dividend  (dvd_a),
      .divisor   (dsr_a),
      .done      (done_a),
      .remainder (rem_a)
   );

   mphi_mod #(
      .DW (DW)
   ) u_mod_b (
      .clock     (clock),
      .reset     (reset),
      .start     (start_b),
      .dividend  (dvd_b),
      .divisor   (gm),
      .done      (done_b),
      .remainder (rem_b)
   );

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      sum_u_in      = sum_u_ff;
      sum_v_in      = sum_v_ff;
      word_ok_in    = word_ok_ff;
      last_in       = last_ff;
      v_in          = v_ff;
      gu_in         = gu_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      depth_in      = depth_ff;
      glen_in       = glen_ff;
      scount_in     = scount_ff;
      g_rd_addr     = v_ff;

      if (csr_we) begin
         case (csr_index)
            mphi_pkg::CSR_DEPTH_IN_USE: depth_in  = csr_wdata[mphi_pkg::DEPTH_W-1:0];
            mphi_pkg::CSR_G_LENGTH:     glen_in   = csr_wdata;
            mphi_pkg::CSR_SAMPLE_COUNT: scount_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (func == mphi_pkg::FUNC_KEY_WORD)) begin
               word_ok_in = (32'(word) < 32'(VOCAB));
               last_in    = (32'(pos_ff) + 32'd1 >= 32'(depth_eff));
               state_in   = ST_ACC;
            end
         end
         ST_ACC: begin
            if (last_ff) begin
               sum_u_in = '0;
               sum_v_in = '0;
               pos_in   = '0;
               state_in = ST_DIV_UV;
            end else begin
               sum_u_in = sum_u_add;
               sum_v_in = sum_v_add;
               pos_in   = pos_ff + PW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_DIV_UV: begin
            if (done_a && done_b) begin
               g_rd_addr = GA_W'(rem_a);
               v_in      = GA_W'(rem_b);
               state_in  = ST_RD_GU;
            end
         end
         ST_RD_GU: begin
            gu_in    = g_rd_data;
            state_in = ST_RD_GV;
         end
         ST_RD_GV: begin
            state_in = ST_DIV_SLOT;
         end
         ST_DIV_SLOT: begin
            if (done_a) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = rem_a[mphi_pkg::SLOT_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pos_ff        <= '0;
         sum_u_ff      <= '0;
         sum_v_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         depth_ff      <= mphi_pkg::DEPTH_RESET;
         glen_ff       <= mphi_pkg::GLEN_RESET;
         scount_ff     <= mphi_pkg::SCOUNT_RESET;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         sum_u_ff      <= sum_u_in;
         sum_v_ff      <= sum_v_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         depth_ff      <= depth_in;
         glen_ff       <= glen_in;
         scount_ff     <= scount_in;
      end
      word_ok_ff   <= word_ok_in;
      last_ff      <= last_in;
      v_ff         <= v_in;
      gu_ff        <= gu_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
